FILE: rtl/core/json_string_unescape_utf8_core_assert.svh
// Assertion macros for the JSON string unescape core.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define JSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication under reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

FILE: rtl/core/jsu_pkg.sv
// Types, codes and helper functions shared by the JSON string unescape core.
`default_nettype none
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX     = 3'd2,
        MODE_HELD    = 3'd3,
        MODE_HELD_BS = 3'd4,
        MODE_HEX_LOW = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_CONT    = 3'd0,
        ST_DONE    = 3'd1,
        ST_UNTERM  = 3'd2,
        ST_BAD_ESC = 3'd3,
        ST_BAD_UNI = 3'd4
    } status_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
    localparam logic [20:0] LOW_SUR_LO  = 21'h0DC00;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       last;
    } result_t;

    // All results caused by one request, in order.
    typedef struct packed {
        result_t [3:0] ent;
        logic [2:0]    count;
    } bundle_t;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] bytes;
    } utf8_t;

    // What one decoding step does: new mode, bytes or a status, hex restart.
    typedef struct packed {
        mode_t           mode;
        logic [2:0]      n;
        logic [3:0][7:0] bytes;
        status_t         status;
        logic            hex_clr;
    } act_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t e;
        e = '0;
        if (cp < 21'h80) begin
            e.n = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.n = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            e.n = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.n = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    function automatic act_t act_normal(input logic [7:0] b);
        act_t a;
        a = '0;
        a.mode = MODE_NORMAL;
        a.status = ST_CONT;
        if (b == CH_QUOTE) begin
            a.status = ST_DONE;
        end else if (b == CH_BSLASH) begin
            a.mode = MODE_ESC;
        end else begin
            a.n = 3'd1;
            a.bytes[0] = b;
        end
        return a;
    endfunction

    function automatic act_t act_escape(input logic [7:0] b);
        act_t a;
        a = '0;
        a.mode = MODE_NORMAL;
        a.status = ST_CONT;
        a.n = 3'd1;
        unique case (b)
            CH_QUOTE:  a.bytes[0] = CH_QUOTE;
            CH_BSLASH: a.bytes[0] = CH_BSLASH;
            CH_SLASH:  a.bytes[0] = CH_SLASH;
            CH_B:      a.bytes[0] = 8'h08;
            CH_F:      a.bytes[0] = 8'h0C;
            CH_N:      a.bytes[0] = 8'h0A;
            CH_R:      a.bytes[0] = 8'h0D;
            CH_T:      a.bytes[0] = 8'h09;
            CH_U:
            begin
                a.n = 3'd0;
                a.mode = MODE_HEX;
                a.hex_clr = 1'b1;
            end
            default:
            begin
                a.n = 3'd0;
                a.status = ST_BAD_ESC;
            end
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/jsu_decode.sv
// Decode state and single-pass decoding of one request into its results.
`default_nettype none
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire item_t   item,
    output bundle_t      bundle
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] held_reg, held_next;

    act_t        act;
    logic        pre;
    logic [4:0]  hv;
    logic [15:0] acc_new;
    logic [15:0] held_diff;
    logic [20:0] cp_pair;
    logic [20:0] cp_sel;
    utf8_t       pre_enc;
    utf8_t       main_enc;
    logic [2:0]  main_n;
    logic [2:0]  total;
    logic [1:0]  j;

    assign hv        = hex_value(item.in_byte);
    assign acc_new   = {acc_reg[11:0], hv[3:0]};
    assign held_diff = held_reg - HIGH_SUR_LO;
    assign cp_pair   = SUPP_BASE + {held_diff[10:0], 10'b0} + {5'b0, acc_new} - LOW_SUR_LO;
    assign cp_sel    = (mode_reg == MODE_HEX_LOW) ? cp_pair : {5'b0, acc_new};
    assign main_enc  = utf8_encode(cp_sel);
    assign pre_enc   = utf8_encode({5'b0, held_reg});

    always_comb
    begin
        act = '0;
        act.mode = mode_reg;
        act.status = ST_CONT;
        pre = 1'b0;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        held_next = held_reg;

        if (item.end_of_input) begin
            act.status = (mode_reg == MODE_HEX || mode_reg == MODE_HEX_LOW)
                         ? ST_BAD_UNI : ST_UNTERM;
        end else begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    act = act_escape(item.in_byte);
                end
                MODE_HEX, MODE_HEX_LOW:
                begin
                    if (!hv[4]) begin
                        act.status = ST_BAD_UNI;
                    end else if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                        acc_next = acc_new;
                    end else begin
                        cnt_next = 2'd0;
                        acc_next = 16'd0;
                        if (mode_reg == MODE_HEX_LOW) begin
                            held_next = 16'd0;
                            act.mode = MODE_NORMAL;
                            act.n = main_enc.n;
                            act.bytes = main_enc.bytes;
                        end else if (acc_new >= HIGH_SUR_LO && acc_new <= HIGH_SUR_HI) begin
                            held_next = acc_new;
                            act.mode = MODE_HELD;
                        end else begin
                            act.mode = MODE_NORMAL;
                            act.n = main_enc.n;
                            act.bytes = main_enc.bytes;
                        end
                    end
                end
                MODE_HELD:
                begin
                    if (item.in_byte == CH_BSLASH) begin
                        act.mode = MODE_HELD_BS;
                    end else begin
                        pre = 1'b1;
                        held_next = 16'd0;
                        act = act_normal(item.in_byte);
                    end
                end
                MODE_HELD_BS:
                begin
                    if (item.in_byte == CH_U) begin
                        act.mode = MODE_HEX_LOW;
                        act.hex_clr = 1'b1;
                    end else begin
                        pre = 1'b1;
                        held_next = 16'd0;
                        act = act_escape(item.in_byte);
                    end
                end
                default:
                begin
                    act = act_normal(item.in_byte);
                end
            endcase
        end

        mode_next = act.mode;
        if (act.hex_clr) begin
            acc_next = 16'd0;
            cnt_next = 2'd0;
        end
        // Any final status drops the whole string state.
        if (act.status != ST_CONT) begin
            mode_next = MODE_NORMAL;
            acc_next = 16'd0;
            cnt_next = 2'd0;
            held_next = 16'd0;
        end
    end

    // Line up the released surrogate bytes ahead of this step's own results.
    always_comb
    begin
        main_n = act.n + {2'b0, act.status != ST_CONT};
        if (pre) begin
            total = (main_n == 3'd0) ? 3'd3 : 3'd4;
        end else begin
            total = main_n;
        end
        bundle = '0;
        bundle.count = total;
        j = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (pre && k < 3) begin
                bundle.ent[k].out_byte = pre_enc.bytes[k];
                bundle.ent[k].byte_valid = 1'b1;
            end else begin
                j = pre ? 2'(k - 3) : 2'(k);
                if ({1'b0, j} < main_n) begin
                    if (act.status != ST_CONT) begin
                        bundle.ent[k].status = act.status;
                    end else begin
                        bundle.ent[k].out_byte = act.bytes[j];
                        bundle.ent[k].byte_valid = 1'b1;
                    end
                end
            end
            bundle.ent[k].last = (3'(k) == total - 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= 16'd0;
            cnt_reg  <= 2'd0;
            held_reg <= 16'd0;
        end else if (advance) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/jsu_serial.sv
// Result buffer that hands out one decoded result per cycle while result_stall is low.
`default_nettype none
module jsu_serial
    import jsu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire bundle_t bundle,
    output logic         free,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg, idx_next;
    logic       full_reg, full_next;
    logic       take;
    logic       take_last;

    assign result_valid = full_reg;
    assign result       = bundle_reg.ent[idx_reg];
    assign take         = full_reg && !result_stall;
    assign take_last    = take && ({1'b0, idx_reg} == bundle_reg.count - 3'd1);
    assign free         = !full_reg || take_last;

    always_comb
    begin
        idx_next = idx_reg;
        full_next = full_reg;
        if (load) begin
            idx_next = 2'd0;
            full_next = 1'b1;
        end else if (take_last) begin
            full_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= 2'd0;
            full_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescape core: input register, decoder, result buffer.
`default_nettype none
`include "json_string_unescape_utf8_core_assert.svh"
// Decodes the body of a JSON string, one request per byte, into UTF-8 result
// bytes followed by a status on the closing quote or on an error. A request
// enters the input register, is decoded in one pass against the string state,
// and its results (none to four) go to a result buffer that hands out one a
// cycle while result_stall is low. A new request is taken every cycle while
// each causes at most one result and result_stall is low; a request that
// causes more results holds the single result port for them in turn, and the
// next request with results waits until the last of them is taken. Bytes sent
// before an error status belong to a broken string and should be dropped downstream.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    advance;
    logic    free;
    logic    load;
    bundle_t bundle;

    assign advance    = in_valid_reg && (bundle.count == 3'd0 || free);
    assign load       = advance && bundle.count != 3'd0;
    assign item_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!item_stall && item_valid) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid) begin
            in_item_reg <= item;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .bundle  (bundle)
    );

    jsu_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .bundle       (bundle),
        .free         (free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `JSU_ASSERT_IMPLY(a_status_is_final, clk, rst_n,
        result_valid && result.status != ST_CONT, result.last)
    `JSU_ASSERT_IMPLY(a_byte_or_status, clk, rst_n,
        result_valid, result.byte_valid != (result.status != ST_CONT))
    `JSU_ASSERT_NEXT(a_request_captured, clk, rst_n,
        item_valid && !item_stall, in_valid_reg)

endmodule
`default_nettype wire
